// ===== rtl/bole_pkg.sv =====
// bole_pkg: constants, operation and status codes, and transaction types
// for the bounded ordered list engine. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bole_pkg;

	// list sizing
	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	// operation codes
	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_INSERT     = 3'd2;
	localparam logic [2:0] OP_POP_FRONT  = 3'd3;
	localparam logic [2:0] OP_POP_BACK   = 3'd4;
	localparam logic [2:0] OP_DELETE     = 3'd5;
	localparam logic [2:0] OP_DUMP       = 3'd6;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	// request transaction
	typedef struct packed {
		logic [2:0]         operation;
		logic signed [31:0] value;
		logic signed [31:0] anchor;
	} req_t;

	// response transaction
	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] data_out;
		logic [4:0]         occupancy;
		logic               last;
	} rsp_t;

endpackage

`default_nettype wire

// ===== rtl/bounded_ordered_list_engine_unit.sv =====
// bounded_ordered_list_engine_unit: ordered list in a small memory, run by a
// sequencer around one read port, one write port and one shared comparator.
// Depends on bole_pkg.
//
//  channel | signals                    | direction | moves
//  --------+----------------------------+-----------+------------------------
//  req     | req_valid, req_ready, req  | in        | one operation
//  rsp     | rsp_valid, rsp_ready, rsp  | out       | one result (dump: many)
//
// Steps: push back writes the entry, then gives its result; push front and
// insert move entries one at a time (a read, then a write per entry moved);
// searches read, then compare, one entry at a time; pops and deletes move the
// tail down one entry at a time (a read, then a write); a dump reads, then
// sends, each entry. The single memory read port sets this pacing.
// Reset clears the count, the sequencer and the response valid; the memory
// is not cleared. req_ready is high only while the sequencer is idle, and
// the sequencer holds in its result states while rsp is stalled.
`timescale 1ns / 1ps
`default_nettype none

module bounded_ordered_list_engine_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire bole_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output bole_pkg::rsp_t     rsp
);

	localparam int IW = bole_pkg::IDX_W;
	localparam int CW = bole_pkg::CNT_W;
	localparam int DW = bole_pkg::DATA_WIDTH;

	// sequencer states
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_SRCH_RD  = 4'd1;
	localparam logic [3:0] S_SRCH_CMP = 4'd2;
	localparam logic [3:0] S_SHR_RD   = 4'd3;
	localparam logic [3:0] S_SHR_WR   = 4'd4;
	localparam logic [3:0] S_INS_WR   = 4'd5;
	localparam logic [3:0] S_REM_RD   = 4'd6;
	localparam logic [3:0] S_REM_GOT  = 4'd7;
	localparam logic [3:0] S_SHL_RD   = 4'd8;
	localparam logic [3:0] S_SHL_WR   = 4'd9;
	localparam logic [3:0] S_DUMP_RD  = 4'd10;
	localparam logic [3:0] S_DUMP_OUT = 4'd11;
	localparam logic [3:0] S_RESULT   = 4'd12;

	// list storage
	logic [DW-1:0] mem [bole_pkg::CAPACITY];
	logic [DW-1:0] rd_data_q;
	logic [IW-1:0] rd_addr;
	logic          mem_we;
	logic [IW-1:0] mem_wa;
	logic [DW-1:0] mem_wd;

	// control state
	logic [3:0]    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          rsp_valid_q;

	// working registers
	logic [2:0]    op_q, op_d;
	logic [DW-1:0] val_q, val_d;
	logic [DW-1:0] key_q, key_d;
	logic [IW-1:0] idx_q, idx_d;
	logic [IW-1:0] lo_q, lo_d;
	logic [DW-1:0] data_q, data_d;
	logic [1:0]    st_q, st_d;
	bole_pkg::rsp_t rsp_q, rsp_d;

	logic          slot_free;
	logic          rsp_load;
	logic          full;
	logic          empty;
	logic          match;
	logic          at_last;
	logic          at_pen;
	logic [IW-1:0] last_idx;
	logic [DW-1:0] in_val;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign full      = (cnt_q == CW'(bole_pkg::CAPACITY));
	assign empty     = (cnt_q == '0);
	assign match     = (rd_data_q == key_q);
	assign last_idx  = IW'(cnt_q - CW'(1));
	assign at_last   = ((CW'(idx_q) + CW'(1)) == cnt_q);
	assign at_pen    = ((CW'(idx_q) + CW'(2)) == cnt_q);
	assign in_val    = DW'($unsigned(req.value));
	assign req_ready = (state_q == S_IDLE);
	assign rd_addr   = (state_q == S_SHL_RD) ? IW'(idx_q + IW'(1)) : idx_q;

	// sequencer next state and datapath control
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		op_d     = op_q;
		val_d    = val_q;
		key_d    = key_q;
		idx_d    = idx_q;
		lo_d     = lo_q;
		data_d   = data_q;
		st_d     = st_q;
		rsp_d    = rsp_q;
		rsp_load = 1'b0;
		mem_we   = 1'b0;
		mem_wa   = idx_q;
		mem_wd   = rd_data_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					op_d   = req.operation;
					val_d  = in_val;
					key_d  = in_val;
					data_d = '0;
					st_d   = bole_pkg::ST_OK;
					idx_d  = '0;
					lo_d   = '0;
					state_d = S_RESULT;
					case (req.operation)
						bole_pkg::OP_PUSH_FRONT: begin
							if (full) st_d = bole_pkg::ST_FULL;
							else if (empty) state_d = S_INS_WR;
							else begin
								idx_d   = last_idx;
								state_d = S_SHR_RD;
							end
						end
						bole_pkg::OP_PUSH_BACK: begin
							if (full) st_d = bole_pkg::ST_FULL;
							else begin
								lo_d    = IW'(cnt_q);
								state_d = S_INS_WR;
							end
						end
						bole_pkg::OP_INSERT: begin
							key_d = DW'($unsigned(req.anchor));
							if (full) st_d = bole_pkg::ST_FULL;
							else if (empty) state_d = S_INS_WR;
							else state_d = S_SRCH_RD;
						end
						bole_pkg::OP_POP_FRONT: begin
							if (empty) st_d = bole_pkg::ST_EMPTY;
							else state_d = S_REM_RD;
						end
						bole_pkg::OP_POP_BACK: begin
							if (empty) st_d = bole_pkg::ST_EMPTY;
							else begin
								idx_d   = last_idx;
								state_d = S_REM_RD;
							end
						end
						bole_pkg::OP_DELETE: begin
							if (empty) st_d = bole_pkg::ST_EMPTY;
							else state_d = S_SRCH_RD;
						end
						bole_pkg::OP_DUMP: begin
							if (empty) st_d = bole_pkg::ST_EMPTY;
							else state_d = S_DUMP_RD;
						end
						default: begin
							st_d = bole_pkg::ST_OK;
						end
					endcase
				end
			end
			// linear search, one entry per read
			S_SRCH_RD: begin
				state_d = S_SRCH_CMP;
			end
			S_SRCH_CMP: begin
				if (match) begin
					if (op_q == bole_pkg::OP_INSERT) begin
						lo_d    = idx_q;
						idx_d   = last_idx;
						state_d = S_SHR_RD;
					end else begin
						state_d = S_REM_GOT;
					end
				end else if (at_last) begin
					st_d    = bole_pkg::ST_NOT_FOUND;
					state_d = S_RESULT;
				end else begin
					idx_d   = IW'(idx_q + IW'(1));
					state_d = S_SRCH_RD;
				end
			end
			// open a gap: move entries up from the tail down to lo
			S_SHR_RD: begin
				state_d = S_SHR_WR;
			end
			S_SHR_WR: begin
				mem_we = 1'b1;
				mem_wa = IW'(idx_q + IW'(1));
				if (idx_q == lo_q) state_d = S_INS_WR;
				else begin
					idx_d   = IW'(idx_q - IW'(1));
					state_d = S_SHR_RD;
				end
			end
			S_INS_WR: begin
				mem_we  = 1'b1;
				mem_wa  = lo_q;
				mem_wd  = val_q;
				cnt_d   = CW'(cnt_q + CW'(1));
				state_d = S_RESULT;
			end
			// take out one entry and close the gap
			S_REM_RD: begin
				state_d = S_REM_GOT;
			end
			S_REM_GOT: begin
				data_d = rd_data_q;
				if (at_last) begin
					cnt_d   = CW'(cnt_q - CW'(1));
					state_d = S_RESULT;
				end else begin
					state_d = S_SHL_RD;
				end
			end
			S_SHL_RD: begin
				state_d = S_SHL_WR;
			end
			S_SHL_WR: begin
				mem_we = 1'b1;
				mem_wa = idx_q;
				if (at_pen) begin
					cnt_d   = CW'(cnt_q - CW'(1));
					state_d = S_RESULT;
				end else begin
					idx_d   = IW'(idx_q + IW'(1));
					state_d = S_SHL_RD;
				end
			end
			// stream every entry, front first
			S_DUMP_RD: begin
				state_d = S_DUMP_OUT;
			end
			S_DUMP_OUT: begin
				if (slot_free) begin
					rsp_load           = 1'b1;
					rsp_d.status       = bole_pkg::ST_OK;
					rsp_d.data_out     = 32'(rd_data_q);
					rsp_d.occupancy    = 5'(cnt_q);
					rsp_d.last         = at_last;
					if (at_last) state_d = S_IDLE;
					else begin
						idx_d   = IW'(idx_q + IW'(1));
						state_d = S_DUMP_RD;
					end
				end
			end
			S_RESULT: begin
				if (slot_free) begin
					rsp_load        = 1'b1;
					rsp_d.status    = st_q;
					rsp_d.data_out  = 32'(data_q);
					rsp_d.occupancy = 5'(cnt_q);
					rsp_d.last      = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// list memory with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_q <= mem[rd_addr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			rsp_valid_q <= rsp_load || (rsp_valid_q && !rsp_ready);
		end
	end

	// working and response payload registers
	always_ff @(posedge clk) begin
		op_q   <= op_d;
		val_q  <= val_d;
		key_q  <= key_d;
		idx_q  <= idx_d;
		lo_q   <= lo_d;
		data_q <= data_d;
		st_q   <= st_d;
		rsp_q  <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ===== dv/tb_bounded_ordered_list_engine_unit.sv =====
// tb_bounded_ordered_list_engine_unit: self-checking testbench for the bounded
// ordered list engine: directed table, then random traffic against a list shadow.
// Depends on bole_pkg and bounded_ordered_list_engine_unit.
`timescale 1ns / 1ps

module tb_bounded_ordered_list_engine_unit;
	import bole_pkg::*;

	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int HOLD_CYCLES     = 300;
	localparam int DRAIN_CYCLES    = 80;
	localparam int ITEMS_PER_PHASE = 30;
	localparam int PRESSURE_ITEMS  = 18;
	localparam int MAX_REPORTS     = 10;

	localparam logic signed [31:0] MIN_VAL = 32'sh8000_0000;
	localparam logic signed [31:0] MAX_VAL = 32'sh7FFF_FFFF;

	// one row of the directed table; typed rows carry their own result
	typedef struct packed {
		logic [2:0]         operation;
		logic signed [31:0] value;
		logic signed [31:0] anchor;
		logic [4:0]         reps;
		logic               typed;
		rsp_t               result;
	} step_row_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	logic signed [31:0] list_shadow[$];
	rsp_t               rsp_due[$];
	step_row_t          steps[$];
	int unsigned        mismatches;
	int unsigned        idle_cycles;
	int unsigned        send_gap_pct;
	int unsigned        rsp_stall_pct;
	bit                 hold_pending;
	bit                 filling;

	bounded_ordered_list_engine_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// position of the first entry equal to key, or -1
	function automatic int find_first(logic signed [31:0] key);
		foreach (list_shadow[i]) begin
			if (list_shadow[i] == key) return i;
		end
		return -1;
	endfunction

	// update the list shadow and queue the results one request causes
	function automatic void apply_list_op(req_t r);
		rsp_t res;
		int   pos;
		res = '0;
		res.last = 1'b1;
		case (r.operation)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (list_shadow.size() >= CAPACITY) res.status = ST_FULL;
				else if (r.operation == OP_PUSH_FRONT) list_shadow.push_front(r.value);
				else list_shadow.push_back(r.value);
			end
			OP_INSERT: begin
				// fullness wins over the anchor search
				pos = find_first(r.anchor);
				if (list_shadow.size() >= CAPACITY) res.status = ST_FULL;
				else if (list_shadow.size() == 0) list_shadow.push_back(r.value);
				else if (pos < 0) res.status = ST_NOT_FOUND;
				else list_shadow.insert(pos, r.value);
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (list_shadow.size() == 0) res.status = ST_EMPTY;
				else if (r.operation == OP_POP_FRONT) res.data_out = list_shadow.pop_front();
				else res.data_out = list_shadow.pop_back();
			end
			OP_DELETE: begin
				pos = find_first(r.value);
				if (list_shadow.size() == 0) res.status = ST_EMPTY;
				else if (pos < 0) res.status = ST_NOT_FOUND;
				else begin
					res.data_out = list_shadow[pos];
					list_shadow.delete(pos);
				end
			end
			OP_DUMP: begin
				// one result per entry, front first, last one marked
				if (list_shadow.size() == 0) res.status = ST_EMPTY;
				else begin
					foreach (list_shadow[i]) begin
						res.data_out  = list_shadow[i];
						res.occupancy = 5'(list_shadow.size());
						res.last      = (i == list_shadow.size() - 1);
						rsp_due.push_back(res);
					end
					return;
				end
			end
			default: ;
		endcase
		res.occupancy = 5'(list_shadow.size());
		rsp_due.push_back(res);
	endfunction

	function automatic step_row_t mk_step(logic [2:0] op, logic signed [31:0] value,
			logic signed [31:0] anchor, logic [4:0] reps, logic typed,
			logic [1:0] status, logic signed [31:0] data, logic [4:0] occ);
		step_row_t row;
		row.operation        = op;
		row.value            = value;
		row.anchor           = anchor;
		row.reps             = reps;
		row.typed            = typed;
		row.result.status    = status;
		row.result.data_out  = data;
		row.result.occupancy = occ;
		row.result.last      = 1'b1;
		return row;
	endfunction

	// values: extremes, a few small repeats for duplicate matches, or anything
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(7))
			0: return MIN_VAL;
			1: return MAX_VAL;
			2: return 32'sd0;
			3: return -32'sd1;
			4, 5: return 32'($urandom_range(7));
			default: return 32'($urandom);
		endcase
	endfunction

	// random request, swinging between filling and draining the list
	function automatic req_t random_request();
		req_t        r;
		int unsigned pick;
		int unsigned n;
		n = list_shadow.size();
		if (n == CAPACITY) filling = 1'b0;
		else if (n == 0) filling = 1'b1;
		else if ($urandom_range(19) == 0) filling = !filling;
		pick = $urandom_range(99);
		if (filling) begin
			if (pick < 20) r.operation = OP_PUSH_FRONT;
			else if (pick < 42) r.operation = OP_PUSH_BACK;
			else if (pick < 64) r.operation = OP_INSERT;
			else if (pick < 72) r.operation = OP_POP_FRONT;
			else if (pick < 80) r.operation = OP_POP_BACK;
			else if (pick < 90) r.operation = OP_DELETE;
			else r.operation = OP_DUMP;
		end else begin
			if (pick < 6) r.operation = OP_PUSH_FRONT;
			else if (pick < 12) r.operation = OP_PUSH_BACK;
			else if (pick < 18) r.operation = OP_INSERT;
			else if (pick < 40) r.operation = OP_POP_FRONT;
			else if (pick < 62) r.operation = OP_POP_BACK;
			else if (pick < 88) r.operation = OP_DELETE;
			else r.operation = OP_DUMP;
		end
		r.value  = pick_value();
		r.anchor = pick_value();
		// mostly aim searches at entries that are present
		if (n != 0 && $urandom_range(3) != 0) begin
			if (r.operation == OP_DELETE) r.value = list_shadow[$urandom_range(n - 1)];
			r.anchor = list_shadow[$urandom_range(n - 1)];
		end
		return r;
	endfunction

	// offer one request and record its results once it is accepted
	task automatic send(req_t r, logic typed, rsp_t typed_rsp);
		while ($urandom_range(99) < send_gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		apply_list_op(r);
		if (typed) begin
			void'(rsp_due.pop_back());
			rsp_due.push_back(typed_rsp);
		end
	endtask

	task automatic flag_mismatch(string what, rsp_t want, rsp_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("%0t: %s: expected status %0d data %0d occ %0d last %0d",
				$realtime, what, want.status, want.data_out, want.occupancy, want.last);
			$display("%0t: %s: got status %0d data %0d occ %0d last %0d",
				$realtime, what, got.status, got.data_out, got.occupancy, got.last);
		end
	endtask

	// main sequence
	initial begin
		req_t r;
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		req           = '0;
		send_gap_pct  = 0;
		rsp_stall_pct = 0;
		hold_pending  = 1'b0;
		filling       = 1'b1;
		mismatches    = 0;
		idle_cycles   = 0;

		// directed table: empty-list cases, one-entry pop, not-found cases, fill to full, full cases, then dump and removals
		steps.push_back(mk_step(OP_INSERT,     32'sd7,     32'sd99,    1, 1, ST_OK,    0,       1));
		steps.push_back(mk_step(OP_POP_FRONT,  0,          0,          1, 1, ST_OK,    32'sd7,  0));
		steps.push_back(mk_step(OP_POP_FRONT,  0,          0,          1, 1, ST_EMPTY, 0,       0));
		steps.push_back(mk_step(OP_DELETE,     32'sd5,     0,          1, 1, ST_EMPTY, 0,       0));
		steps.push_back(mk_step(OP_DUMP,       0,          0,          1, 1, ST_EMPTY, 0,       0));
		steps.push_back(mk_step(OP_PUSH_FRONT, MIN_VAL,    0,          1, 1, ST_OK,    0,       1));
		steps.push_back(mk_step(OP_PUSH_BACK,  MAX_VAL,    0,          1, 1, ST_OK,    0,       2));
		steps.push_back(mk_step(OP_INSERT,     -32'sd1,    MAX_VAL,    1, 1, ST_OK,    0,       3));
		steps.push_back(mk_step(OP_INSERT,     32'sd3,     32'sd12345, 1, 1, ST_NOT_FOUND, 0,   3));
		steps.push_back(mk_step(OP_DELETE,     32'sd12345, 0,          1, 1, ST_NOT_FOUND, 0,   3));
		steps.push_back(mk_step(OP_PUSH_BACK,  32'sh5A5A_0000, 0,     13, 0, ST_OK,    0,       0));
		steps.push_back(mk_step(OP_PUSH_FRONT, 32'sd1,     0,          1, 1, ST_FULL,  0,      16));
		steps.push_back(mk_step(OP_INSERT,     32'sd3,     MIN_VAL,    1, 1, ST_FULL,  0,      16));
		steps.push_back(mk_step(OP_DUMP,       0,          0,          1, 0, ST_OK,    0,       0));
		steps.push_back(mk_step(OP_POP_FRONT,  0,          0,          1, 1, ST_OK,    MIN_VAL, 15));
		steps.push_back(mk_step(OP_POP_BACK,   0,          0,          1, 0, ST_OK,    0,       0));
		steps.push_back(mk_step(OP_DELETE,     -32'sd1,    0,          1, 1, ST_OK,    -32'sd1, 13));

		// reset
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		foreach (steps[k]) begin
			for (int j = 0; j < steps[k].reps; j++) begin
				r.operation = steps[k].operation;
				r.value     = steps[k].value + 32'(j);
				r.anchor    = steps[k].anchor;
				send(r, steps[k].typed, steps[k].result);
			end
		end

		// random part over four phases: no gaps, send gaps, result stalls, then both
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin send_gap_pct = 0;  rsp_stall_pct = 0;  end
				1: begin send_gap_pct = 53; rsp_stall_pct = 0;  end
				2: begin send_gap_pct = 0;  rsp_stall_pct = 53; end
				default: begin send_gap_pct = 38; rsp_stall_pct = 38; end
			endcase
			repeat (ITEMS_PER_PHASE) send(random_request(), 1'b0, '0);
		end

		// long receiver hold-off while requests keep coming
		send_gap_pct  = 0;
		rsp_stall_pct = 0;
		hold_pending  = 1'b1;
		repeat (PRESSURE_ITEMS) send(random_request(), 1'b0, '0);
		req_valid <= 1'b0;

		// drain
		while (rsp_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// result receiver: random stalls plus one long hold-off on request
	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (rsp_due.size() == 0) begin
				flag_mismatch("unexpected transaction", '0, rsp);
			end else begin
				want = rsp_due.pop_front();
				if (rsp.status !== want.status || rsp.data_out !== want.data_out ||
						rsp.occupancy !== want.occupancy || rsp.last !== want.last)
					flag_mismatch("result mismatch", want, rsp);
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
